[src/sha256_stream_hasher_defines.svh]
// Assertion macros shared by the hasher modules.
// Each macro expects clk_i and rst_ni in scope at its point of use.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SHA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/sha_pkg.sv]
// Shared types, constants and helper functions for the SHA-256 stream hasher.
// No dependencies.
package sha_pkg;

  localparam int unsigned SHA_QDEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One 64-byte block bound for compression; is_last asks for the digest.
  typedef struct packed {
    logic [511:0] data;
    logic         is_last;
  } blk_t;

  typedef enum logic [1:0] {F_IN, F_FULL, F_PAD, F_LEN} front_state_e;
  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD, C_OUT} core_state_e;

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] SHA_PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[src/sha_front.sv]
// Front end: collects message bytes into blocks and builds the padding blocks.
// Depends on sha_pkg.
module sha_front
  import sha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output blk_t     blk_o,
  input  logic     full_i
);

  front_state_e      state_q, state_d;
  logic [0:63][7:0]  buf_q;
  logic [5:0]        fill_q, fill_d;
  logic [63:0]       bits_q, bits_d;
  logic              end_q, end_d;
  logic [0:63][7:0]  pad_bytes;
  logic              len_fits;
  logic              accept;

  assign accept = in_valid_i && in_ready_o;

  // Byte store: one write per accepted byte, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.byte_present) begin
      buf_q[fill_q] <= in_item_i.data_byte;
    end
  end

  // Padding view of the buffer: drop stale bytes, mark the end, add the length.
  always_comb begin
    len_fits = (state_q == F_LEN) || (fill_q < 6'd56);
    for (int i = 0; i < 64; i++) begin
      if (state_q == F_LEN) begin
        pad_bytes[i] = '0;
      end else if (6'(i) < fill_q) begin
        pad_bytes[i] = buf_q[i];
      end else if (6'(i) == fill_q) begin
        pad_bytes[i] = SHA_PAD_BYTE;
      end else begin
        pad_bytes[i] = '0;
      end
    end
    if (len_fits) begin
      for (int k = 0; k < 8; k++) begin
        pad_bytes[56 + k] = bits_q[(63 - 8 * k) -: 8];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    bits_d     = bits_q;
    end_d      = end_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    blk_o.data    = pad_bytes;
    blk_o.is_last = 1'b0;
    case (state_q)
      F_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          end_d = in_item_i.message_end;
          if (in_item_i.byte_present) begin
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
            if (fill_q == 6'd63) begin
              state_d = F_FULL;
            end else if (in_item_i.message_end) begin
              state_d = F_PAD;
            end
          end else if (in_item_i.message_end) begin
            state_d = F_PAD;
          end
        end
      end
      F_FULL: begin
        blk_o.data = buf_q;
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = end_q ? F_PAD : F_IN;
        end
      end
      F_PAD: begin
        blk_o.is_last = len_fits;
        if (!full_i) begin
          push_o = 1'b1;
          if (len_fits) begin
            fill_d  = '0;
            bits_d  = '0;
            state_d = F_IN;
          end else begin
            state_d = F_LEN;
          end
        end
      end
      F_LEN: begin
        blk_o.is_last = 1'b1;
        if (!full_i) begin
          push_o  = 1'b1;
          fill_d  = '0;
          bits_d  = '0;
          state_d = F_IN;
        end
      end
      default: state_d = F_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IN;
      fill_q  <= '0;
      bits_q  <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      end_q   <= end_d;
    end
  end

endmodule

[src/sha_fifo.sv]
// Short block queue between the front end and the compression core.
// Depends on sha_pkg and the assertion macros header.
`include "sha256_stream_hasher_defines.svh"
module sha_fifo
  import sha_pkg::*;
#(
  parameter int unsigned Depth = SHA_QDEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  blk_t blk_i,
  output logic full_o,
  input  logic pop_i,
  output blk_t blk_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  blk_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign blk_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= blk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `SHA_ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")
  `SHA_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty queue")
  `SHA_ASSERT(a_cnt_push, (push_i && !pop_i) |=> !empty_o, "queue empty after push")

endmodule

[src/sha_core.sv]
// Compression core: 64 rounds per block, chaining update and digest readout.
// Depends on sha_pkg and the assertion macros header.
`include "sha256_stream_hasher_defines.svh"
module sha_core
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  blk_t      blk_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  core_state_e       state_q, state_d;
  logic [0:7][31:0]  h_q;
  logic [0:7][31:0]  v_q;
  logic [0:15][31:0] w_q;
  logic [5:0]        rnd_q;
  logic [2:0]        idx_q;
  logic              last_q;
  logic [31:0]       t1, t2, w_new;

  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + SHA_K[rnd_q] + w_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = C_ADD;
        end
      end
      C_ADD: state_d = last_q ? C_OUT : C_IDLE;
      C_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && idx_q == 3'd7) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  assign out_item_o.digest_word = h_q[idx_q];
  assign out_item_o.word_index  = idx_q;
  assign out_item_o.last_word   = (idx_q == 3'd7);

  // Working registers and schedule window carry no reset.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      v_q    <= h_q;
      w_q    <= blk_i.data;
      last_q <= blk_i.is_last;
    end else if (state_q == C_ROUND) begin
      v_q <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
      w_q <= {w_q[1:15], w_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      h_q     <= SHA_IV;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == C_ROUND) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (state_q == C_ADD) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end
      if (out_valid_o && out_ready_i) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          h_q <= SHA_IV;
        end
      end
    end
  end

  `SHA_ASSERT(a_iv_after, (out_valid_o && out_ready_i && idx_q == 3'd7) |=> (h_q == SHA_IV), "chain not reinitialised after digest")
  `SHA_ASSERT_NEVER(a_pop_busy, pop_o && (rnd_q != 6'd0), "block popped mid-compression")
  `SHA_ASSERT(a_round_end, (state_q == C_ROUND && rnd_q == 6'd63) |=> (state_q == C_ADD), "round count overrun")

endmodule

[src/sha256_stream_hasher.sv]
// Top level of the SHA-256 stream hasher: front end, block queue, compression core.
// Depends on sha_pkg, sha_front, sha_fifo and sha_core.
//
//  channel | direction | handshake            | payload
//  in      | request   | in_valid_i/in_ready_o   | in_item_i  (in_item_t)
//  out     | response  | out_valid_o/out_ready_i | out_item_o (out_item_t)
//
// The front hands each completed block over in a state of its own. In the core each
// block passes through a load, 64 rounds at one round per cycle and a chaining add,
// so long messages run at about one byte per cycle while the output is not held, set
// by the single shared round unit. A digest is read out as eight words.
// Reset is asynchronous, active low, and restores the initial chaining words.
// The queue holds QDepth blocks; the front stalls input while it hands over a full
// block or a padding block, and longer while the queue is full; the core stalls only
// on its own output.
module sha256_stream_hasher
  import sha_pkg::*;
#(
  parameter int unsigned QDepth = SHA_QDEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic push, full, pop, empty;
  blk_t blk_in, blk_out;

  // Classify requests and build blocks, padding included.
  sha_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .blk_o      (blk_in),
    .full_i     (full)
  );

  // Hold finished blocks so the front keeps taking bytes during compression.
  sha_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .blk_i   (blk_in),
    .full_o  (full),
    .pop_i   (pop),
    .blk_o   (blk_out),
    .empty_o (empty)
  );

  // Compress blocks and present the digest one word at a time.
  sha_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .blk_i       (blk_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
